// ----- sv/macs_pkg.sv -----
// shared constants and codes for the moving average crossover signal block
`default_nettype none

package macs_pkg;

  // default sizing
  localparam int MAX_PERIOD_DEF = 256;
  localparam int PRICE_BITS_DEF = 32;

  // fixed port widths
  localparam int PRICE_IN_W = 32;
  localparam int PERIOD_W   = 9;
  localparam int ACTION_W   = 3;
  localparam int CFG_IDX_W  = 1;

  // result queue depth, covers the pipeline latency at full rate
  localparam int FIFO_DEPTH = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FAST_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD = 1'b1;

  // register reset values
  localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = 9'd10;
  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = 9'd30;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_NONE            = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_BUY             = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_CLOSE_SHORT_BUY = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SELL            = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLOSE_LONG_SELL = 3'd4;

endpackage

`default_nettype wire

// ----- sv/macs_ram.sv -----
// generic single write, single read ram with registered read data
`default_nettype none

module macs_ram #(
  parameter int Width = 32,
  parameter int Depth = 257
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/moving_average_crossover_signal.sv -----
// top level of the simple moving average crossover signal block
`default_nettype none

// Takes one closing price per transfer with the sign of the current position
// and returns one action code per item: none, buy, close short then buy, sell,
// or close long then sell. A buy follows the fast average rising strictly
// above the slow one, a sell follows it falling strictly below; averages are
// compared exactly by cross-multiplying window sums with periods. Nothing is
// signalled until slow_period samples have arrived. Prices are stored in a
// history ram of MAX_PERIOD+1 entries, and two ungated running sums are kept,
// updated with the two samples that leave the windows; those two reads are
// served by two copies of the history ram, one read port each. One item is
// accepted every cycle while in_ready is high; a result passes through the
// history read, sum update, multiply and compare steps before it is queued.
// A small result queue lets input keep flowing while the consumer stalls. A
// write to either period register starts a rebuild of the running sums from
// the history; in_ready stays low during it.
module moving_average_crossover_signal
  import macs_pkg::*;
#(
  parameter int MAX_PERIOD = MAX_PERIOD_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic        [PRICE_IN_W-1:0] close_price,
  input  wire logic signed [1:0]            position_sign,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic             [ACTION_W-1:0]   action,
  // configuration writes
  input  wire logic                        cfg_write,
  input  wire logic        [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [PERIOD_W-1:0]   cfg_data
);

  localparam int HistDepth = MAX_PERIOD + 1;
  localparam int AddrW     = $clog2(HistDepth);
  localparam int EffW      = $clog2(MAX_PERIOD + 1);
  localparam int CntW      = $clog2(HistDepth + 1);
  localparam int SumW      = PRICE_BITS + EffW;
  localparam int ProdW     = SumW + EffW;
  localparam int FifoAw    = $clog2(FIFO_DEPTH);
  localparam int UsedW     = $clog2(FIFO_DEPTH + 1);

  // configuration registers
  logic [PERIOD_W-1:0] fast_period;
  logic [PERIOD_W-1:0] slow_period;
  logic [EffW-1:0]     fp_eff;
  logic [EffW-1:0]     sp_eff;

  // history bookkeeping
  logic [AddrW-1:0]    wr_ptr;
  logic [CntW-1:0]     sample_count;
  logic [CntW-1:0]     count_next;
  logic [AddrW:0]      fast_addr_raw;
  logic [AddrW:0]      slow_addr_raw;
  logic [AddrW-1:0]    fast_addr;
  logic [AddrW-1:0]    slow_addr;
  logic [AddrW-1:0]    fast_raddr;
  logic [PRICE_BITS-1:0] price_in;
  logic [PRICE_BITS-1:0] rd_fast;
  logic [PRICE_BITS-1:0] rd_slow;

  // ungated running window sums
  logic [SumW-1:0]     fast_run;
  logic [SumW-1:0]     slow_run;
  logic [SumW-1:0]     fast_run_next;
  logic [SumW-1:0]     slow_run_next;

  // rebuild sweep after a period change
  logic                sweep_issue;
  logic [EffW-1:0]     sweep_k;
  logic [AddrW-1:0]    sweep_addr;
  logic                sweep_dv;
  logic [EffW-1:0]     sweep_kd;

  // handshake
  logic                accept;
  logic                out_xfer;
  logic [UsedW-1:0]    used;

  // stage 1: input item with history read data arriving
  logic                  s1_valid;
  logic [PRICE_BITS-1:0] s1_price;
  logic                  s1_short;
  logic                  s1_long;
  logic                  s1_f_gt;
  logic                  s1_f_ge;
  logic                  s1_s_gt;
  logic                  s1_s_ge;

  // stage 2: gated window sums
  logic            s2_valid;
  logic [SumW-1:0] s2_fnow;
  logic [SumW-1:0] s2_fbef;
  logic [SumW-1:0] s2_snow;
  logic [SumW-1:0] s2_sbef;
  logic            s2_warm;
  logic            s2_short;
  logic            s2_long;

  // stage 3: cross products
  logic             s3_valid;
  logic [ProdW-1:0] s3_fnow_x;
  logic [ProdW-1:0] s3_snow_x;
  logic [ProdW-1:0] s3_fbef_x;
  logic [ProdW-1:0] s3_sbef_x;
  logic             s3_warm;
  logic             s3_short;
  logic             s3_long;
  logic [ACTION_W-1:0] s3_action;

  // result queue
  logic [ACTION_W-1:0] fifo_mem [FIFO_DEPTH];
  logic [FifoAw-1:0]   fifo_wr;
  logic [FifoAw-1:0]   fifo_rd;
  logic [UsedW-1:0]    fifo_count;

  // a period of zero acts as one, one longer than MAX_PERIOD acts as MAX_PERIOD
  always_comb begin
    if (fast_period == '0) begin
      fp_eff = EffW'(1);
    end else if (int'(fast_period) > MAX_PERIOD) begin
      fp_eff = EffW'(MAX_PERIOD);
    end else begin
      fp_eff = EffW'(fast_period);
    end
    if (slow_period == '0) begin
      sp_eff = EffW'(1);
    end else if (int'(slow_period) > MAX_PERIOD) begin
      sp_eff = EffW'(MAX_PERIOD);
    end else begin
      sp_eff = EffW'(slow_period);
    end
  end

  assign in_ready = (int'(used) < FIFO_DEPTH) && !sweep_issue && !sweep_dv;
  assign accept   = in_valid && in_ready;
  assign out_valid = (fifo_count != '0);
  assign out_xfer  = out_valid && out_ready;
  assign action    = fifo_mem[fifo_rd];

  assign price_in = PRICE_BITS'(close_price);

  // sample count after this item, saturating one above the longest window
  assign count_next = (int'(sample_count) < HistDepth) ? sample_count + 1'b1 : sample_count;

  // samples leaving the windows sit period entries back from the new one
  always_comb begin
    fast_addr_raw = {1'b0, wr_ptr} + (AddrW + 1)'(HistDepth) - (AddrW + 1)'(fp_eff);
    slow_addr_raw = {1'b0, wr_ptr} + (AddrW + 1)'(HistDepth) - (AddrW + 1)'(sp_eff);
    if (int'(fast_addr_raw) >= HistDepth) begin
      fast_addr = AddrW'(fast_addr_raw - (AddrW + 1)'(HistDepth));
    end else begin
      fast_addr = AddrW'(fast_addr_raw);
    end
    if (int'(slow_addr_raw) >= HistDepth) begin
      slow_addr = AddrW'(slow_addr_raw - (AddrW + 1)'(HistDepth));
    end else begin
      slow_addr = AddrW'(slow_addr_raw);
    end
  end

  // the fast copy also serves the rebuild sweep
  assign fast_raddr = sweep_issue ? sweep_addr : fast_addr;

  macs_ram #(
    .Width (PRICE_BITS),
    .Depth (HistDepth)
  ) u_hist_fast (
    .clk   (clk),
    .we    (accept),
    .waddr (wr_ptr),
    .wdata (price_in),
    .raddr (fast_raddr),
    .rdata (rd_fast)
  );

  macs_ram #(
    .Width (PRICE_BITS),
    .Depth (HistDepth)
  ) u_hist_slow (
    .clk   (clk),
    .we    (accept),
    .waddr (wr_ptr),
    .wdata (price_in),
    .raddr (slow_addr),
    .rdata (rd_slow)
  );

  // running sums: add the new sample, drop the one leaving once a window is full
  always_comb begin
    fast_run_next = fast_run + SumW'(s1_price) - (s1_f_gt ? SumW'(rd_fast) : '0);
    slow_run_next = slow_run + SumW'(s1_price) - (s1_s_gt ? SumW'(rd_slow) : '0);
  end

  // compare the averages now and one sample earlier
  always_comb begin
    logic now_gt;
    logic now_lt;
    logic bef_gt;
    logic bef_lt;
    logic cross_above;
    logic cross_below;
    now_gt = s3_fnow_x > s3_snow_x;
    now_lt = s3_fnow_x < s3_snow_x;
    bef_gt = s3_fbef_x > s3_sbef_x;
    bef_lt = s3_fbef_x < s3_sbef_x;
    cross_above = !bef_gt && now_gt;
    cross_below = !bef_lt && now_lt;
    s3_action = ACT_NONE;
    if (s3_warm) begin
      if (cross_above && !s3_long) begin
        s3_action = s3_short ? ACT_CLOSE_SHORT_BUY : ACT_BUY;
      end else if (cross_below && !s3_short) begin
        s3_action = s3_long ? ACT_CLOSE_LONG_SELL : ACT_SELL;
      end
    end
  end

  // configuration, history pointer, running sums and rebuild sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_period  <= FAST_PERIOD_RST;
      slow_period  <= SLOW_PERIOD_RST;
      wr_ptr       <= '0;
      sample_count <= '0;
      fast_run     <= '0;
      slow_run     <= '0;
      sweep_issue  <= 1'b0;
      sweep_k      <= '0;
      sweep_addr   <= '0;
      sweep_dv     <= 1'b0;
      sweep_kd     <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FAST_PERIOD: fast_period <= cfg_data;
          REG_SLOW_PERIOD: slow_period <= cfg_data;
          default: ;
        endcase
        // restart the sweep from the newest sample
        sweep_issue <= 1'b1;
        sweep_k     <= '0;
        sweep_addr  <= (wr_ptr == '0) ? AddrW'(HistDepth - 1) : wr_ptr - 1'b1;
        sweep_dv    <= 1'b0;
        fast_run    <= '0;
        slow_run    <= '0;
      end else begin
        if (sweep_issue) begin
          sweep_k    <= sweep_k + 1'b1;
          sweep_addr <= (sweep_addr == '0) ? AddrW'(HistDepth - 1) : sweep_addr - 1'b1;
          sweep_kd   <= sweep_k;
          sweep_dv   <= 1'b1;
          if (int'(sweep_k) == MAX_PERIOD - 1) begin
            sweep_issue <= 1'b0;
          end
        end else begin
          sweep_dv <= 1'b0;
        end
        if (sweep_dv) begin
          // entry sweep_kd samples back belongs to each window it reaches into
          if (sweep_kd < fp_eff && int'(sweep_kd) < int'(sample_count)) begin
            fast_run <= fast_run + SumW'(rd_fast);
          end
          if (sweep_kd < sp_eff && int'(sweep_kd) < int'(sample_count)) begin
            slow_run <= slow_run + SumW'(rd_fast);
          end
        end else if (s1_valid) begin
          fast_run <= fast_run_next;
          slow_run <= slow_run_next;
        end
      end
      if (accept) begin
        wr_ptr       <= (int'(wr_ptr) == HistDepth - 1) ? '0 : wr_ptr + 1'b1;
        sample_count <= count_next;
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    // stage 1: window gating from the count after this sample
    s1_price <= price_in;
    s1_short <= position_sign[1];
    s1_long  <= (position_sign == 2'sb01);
    s1_f_gt  <= int'(count_next) > int'(fp_eff);
    s1_f_ge  <= int'(count_next) >= int'(fp_eff);
    s1_s_gt  <= int'(count_next) > int'(sp_eff);
    s1_s_ge  <= int'(count_next) >= int'(sp_eff);
    // stage 2: a window reaching past the samples seen counts as zero
    s2_fnow  <= s1_f_ge ? fast_run_next : '0;
    s2_fbef  <= s1_f_gt ? fast_run : '0;
    s2_snow  <= s1_s_ge ? slow_run_next : '0;
    s2_sbef  <= s1_s_gt ? slow_run : '0;
    s2_warm  <= s1_s_ge;
    s2_short <= s1_short;
    s2_long  <= s1_long;
    // stage 3: fast_sum * slow_period against slow_sum * fast_period
    s3_fnow_x <= ProdW'(s2_fnow) * ProdW'(sp_eff);
    s3_snow_x <= ProdW'(s2_snow) * ProdW'(fp_eff);
    s3_fbef_x <= ProdW'(s2_fbef) * ProdW'(sp_eff);
    s3_sbef_x <= ProdW'(s2_sbef) * ProdW'(fp_eff);
    s3_warm   <= s2_warm;
    s3_short  <= s2_short;
    s3_long   <= s2_long;
  end

  // result queue and occupancy, counting items still in the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_wr    <= '0;
      fifo_rd    <= '0;
      fifo_count <= '0;
      used       <= '0;
    end else begin
      if (s3_valid) begin
        fifo_wr <= fifo_wr + 1'b1;
      end
      if (out_xfer) begin
        fifo_rd <= fifo_rd + 1'b1;
      end
      fifo_count <= fifo_count + UsedW'(s3_valid) - UsedW'(out_xfer);
      used       <= used + UsedW'(accept) - UsedW'(out_xfer);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      fifo_mem[fifo_wr] <= s3_action;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the moving average crossover signal block
module tb_top;
  import macs_pkg::*;

  // history depth and run sizing
  localparam int HIST_LEN       = MAX_PERIOD_DEF + 1;
  localparam int RAND_ITEMS     = 1650;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int SQUEEZE_PHASE  = 2;

  // position codes as they appear on the port
  localparam logic [1:0] POS_FLAT       = 2'b00;
  localparam logic [1:0] POS_LONG       = 2'b01;
  localparam logic [1:0] POS_SHORT_ALT  = 2'b10;
  localparam logic [1:0] POS_SHORT      = 2'b11;

  // one row of the directed table: a register write or a price transfer
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [PERIOD_W-1:0]   reg_val;
    logic [PRICE_IN_W-1:0] price;
    logic [1:0]            pos;
    logic                  known;
    logic [ACTION_W-1:0]   act;
  } plan_row_t;

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  // dut connections, all inputs known from time zero
  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic        [PRICE_IN_W-1:0] close_price = '0;
  logic signed [1:0]            position_sign = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic        [ACTION_W-1:0]   action;
  logic                         cfg_write = 1'b0;
  logic        [CFG_IDX_W-1:0]  cfg_index = REG_FAST_PERIOD;
  logic        [PERIOD_W-1:0]   cfg_data = '0;

  // predictor state: own copy of the price history, fill level and periods
  logic [PRICE_IN_W-1:0] price_log [0:HIST_LEN-1];
  int                    log_wr = 0;
  int                    log_fill = 0;
  logic [PERIOD_W-1:0]   fast_len_reg = FAST_PERIOD_RST;
  logic [PERIOD_W-1:0]   slow_len_reg = SLOW_PERIOD_RST;

  // actions still owed by the block, oldest first
  logic [ACTION_W-1:0]   action_q [$];

  int                    errors = 0;
  int                    cycle_count = 0;
  int                    burst_left = 0;
  logic [PRICE_IN_W-1:0] walk_price = 32'h0064_0000;

  // long receiver hold-off, requested by the stimulus, timed by the receiver
  bit                    squeeze_req = 1'b0;
  bit                    squeeze_done = 1'b0;
  int                    squeeze_left = 0;
  rx_mode_t              rx_mode = RX_OPEN;
  int                    rx_mode_left = 0;

  always #5 clk = ~clk;

  moving_average_crossover_signal uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .close_price   (close_price),
    .position_sign (position_sign),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // zero acts as one, anything past the history acts as the longest window
  function automatic int clamp_period(logic [PERIOD_W-1:0] p);
    if (p == 0) return 1;
    if (p > MAX_PERIOD_DEF) return MAX_PERIOD_DEF;
    return int'(p);
  endfunction

  // sum of len prices ending back samples before the newest;
  // a window that reaches past the filled history counts as zero
  function automatic logic [63:0] window_total(int len, int back);
    logic [63:0] total;
    int          idx;
    total = '0;
    if (log_fill < len + back) return '0;
    for (int i = back; i < len + back; i++) begin
      idx = (log_wr + HIST_LEN - 1 - i) % HIST_LEN;
      total += 64'(price_log[idx]);
    end
    return total;
  endfunction

  // sign of fast average minus slow average, by cross-multiplication
  function automatic int avg_order(logic [63:0] fs, int fl, logic [63:0] ss, int sl);
    logic [63:0] lhs;
    logic [63:0] rhs;
    lhs = fs * 64'(sl);
    rhs = ss * 64'(fl);
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    return 0;
  endfunction

  // store one price and work out the action it causes
  function automatic logic [ACTION_W-1:0] crossover_action(logic [PRICE_IN_W-1:0] price,
                                                           logic [1:0] pos);
    int                  fl;
    int                  sl;
    int                  now_ord;
    int                  prev_ord;
    logic                is_short;
    logic                is_long;
    logic [ACTION_W-1:0] act;
    fl = clamp_period(fast_len_reg);
    sl = clamp_period(slow_len_reg);
    // the top bit alone marks a short, so the unused code counts as short
    is_short = pos[1];
    is_long  = (pos == POS_LONG);
    price_log[log_wr] = price;
    log_wr = (log_wr + 1) % HIST_LEN;
    if (log_fill < HIST_LEN) log_fill++;
    act = ACT_NONE;
    // warm-up: quiet until the slow window has filled
    if (log_fill >= sl) begin
      now_ord  = avg_order(window_total(fl, 0), fl, window_total(sl, 0), sl);
      prev_ord = avg_order(window_total(fl, 1), fl, window_total(sl, 1), sl);
      if (prev_ord <= 0 && now_ord > 0 && !is_long) begin
        act = is_short ? ACT_CLOSE_SHORT_BUY : ACT_BUY;
      end else if (prev_ord >= 0 && now_ord < 0 && !is_short) begin
        act = is_long ? ACT_CLOSE_LONG_SELL : ACT_SELL;
      end
    end
    return act;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic plan_row_t price_row(logic [PRICE_IN_W-1:0] price, logic [1:0] pos,
                                          logic known, logic [ACTION_W-1:0] act);
    plan_row_t r;
    r = '0;
    r.price = price;
    r.pos   = pos;
    r.known = known;
    r.act   = act;
    return r;
  endfunction

  // mostly a random walk, so averages cross often, with jumps and extremes
  function automatic logic [PRICE_IN_W-1:0] next_price();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: begin
        walk_price = walk_price + 32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20);
        return walk_price;
      end
    endcase
  endfunction

  // period values at and beyond the legal edges
  function automatic logic [PERIOD_W-1:0] extreme_period();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 9'd1;
      2:       return 9'd256;
      3:       return 9'($urandom_range(257, 510));
      default: return 9'd511;
    endcase
  endfunction

  // one register write; starts on a fresh edge so write enable never
  // gets two updates in one step
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_FAST_PERIOD) fast_len_reg = val;
    else slow_len_reg = val;
  endtask

  // stop offering and wait until every owed action has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (action_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // offer one price; the sender runs in bursts, most of them followed by an idle gap
  task automatic offer_price(logic [PRICE_IN_W-1:0] price, logic [1:0] pos,
                             logic known, logic [ACTION_W-1:0] known_act);
    int                  gap;
    logic [ACTION_W-1:0] act;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid      <= 1'b1;
    close_price   <= price;
    position_sign <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer taken at this edge
    act = crossover_action(price, pos);
    action_q.push_back(known ? known_act : act);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: own stall pattern plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (squeeze_left != 0) begin
      squeeze_left <= squeeze_left - 1;
      out_ready    <= 1'b0;
    end else if (squeeze_req && !squeeze_done) begin
      // hold off long enough for the result queue and the input to back up
      squeeze_left <= SQUEEZE_CYCLES;
      squeeze_done <= 1'b1;
      out_ready    <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(16, 96);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result check: every transfer against the oldest owed action
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_actions
    logic [ACTION_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (action_q.size() == 0) begin
        $display("%0t: action transfer with nothing owed, expected none, got %0d",
                 $time, action);
        errors++;
      end else begin
        want = action_q.pop_front();
        if (action !== want) begin
          $display("%0t: action mismatch, expected %0d, got %0d", $time, want, action);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t           plan [$];
    int                  fed;
    int                  phase;
    int                  phase_len;
    logic [PERIOD_W-1:0] fast_pick;
    logic [PERIOD_W-1:0] slow_pick;

    // directed table: tiny windows first so crossings come at once
    plan.push_back(cfg_row(REG_FAST_PERIOD, 9'd1));
    plan.push_back(cfg_row(REG_SLOW_PERIOD, 9'd2));
    // first sample is still warm-up
    plan.push_back(price_row(32'd100 << 16, POS_FLAT, 1'b1, ACT_NONE));
    plan.push_back(price_row(32'd200 << 16, POS_FLAT, 1'b0, ACT_NONE));
    // fall, rise, fall, rise with each position
    plan.push_back(price_row(32'd50 << 16, POS_LONG, 1'b0, ACT_NONE));
    plan.push_back(price_row(32'd300 << 16, POS_SHORT, 1'b0, ACT_NONE));
    plan.push_back(price_row(32'd10 << 16, POS_FLAT, 1'b0, ACT_NONE));
    plan.push_back(price_row(32'hFFFF_FFFF, POS_FLAT, 1'b0, ACT_NONE));
    // unused position code behaves as short
    plan.push_back(price_row(32'h0000_0000, POS_SHORT_ALT, 1'b0, ACT_NONE));
    plan.push_back(price_row(32'hFFFF_FFFF, POS_SHORT_ALT, 1'b0, ACT_NONE));
    // equal averages, then a drop, then flat at zero
    plan.push_back(price_row(32'hFFFF_FFFF, POS_LONG, 1'b0, ACT_NONE));
    plan.push_back(price_row(32'h0000_0000, POS_LONG, 1'b0, ACT_NONE));
    plan.push_back(price_row(32'h0000_0000, POS_FLAT, 1'b0, ACT_NONE));
    // zero period acts as one, oversized slow period clamps and re-enters warm-up
    plan.push_back(cfg_row(REG_FAST_PERIOD, 9'd0));
    plan.push_back(cfg_row(REG_SLOW_PERIOD, 9'd511));
    plan.push_back(price_row(32'd12345, POS_FLAT, 1'b1, ACT_NONE));
    plan.push_back(price_row(32'hA5A5_A5A5, POS_LONG, 1'b1, ACT_NONE));
    // long fast window over a short history counts as zero
    plan.push_back(cfg_row(REG_FAST_PERIOD, 9'd300));
    plan.push_back(cfg_row(REG_SLOW_PERIOD, 9'd0));
    plan.push_back(price_row(32'h5A5A_5A5A, POS_SHORT, 1'b0, ACT_NONE));
    plan.push_back(price_row(32'h0000_0001, POS_FLAT, 1'b0, ACT_NONE));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        // registers only change with nothing in flight
        drain_results();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        offer_price(plan[i].price, plan[i].pos, plan[i].known, plan[i].act);
      end
    end
    drain_results();

    // random phases, each under its own pair of periods
    fed = 0;
    phase = 0;
    while (fed < RAND_ITEMS) begin
      case ($urandom_range(0, 7))
        0: begin
          fast_pick = extreme_period();
          slow_pick = extreme_period();
        end
        1: begin
          // fast window longer than the slow one
          fast_pick = 9'($urandom_range(20, 80));
          slow_pick = 9'($urandom_range(1, 10));
        end
        2: begin
          fast_pick = 9'($urandom_range(1, 40));
          slow_pick = 9'($urandom_range(150, 256));
        end
        default: begin
          fast_pick = 9'($urandom_range(1, 8));
          slow_pick = fast_pick + 9'($urandom_range(1, 24));
        end
      endcase
      // now and then one register keeps its old value
      if ($urandom_range(0, 4) != 0) write_reg(REG_FAST_PERIOD, fast_pick);
      if ($urandom_range(0, 4) != 0) write_reg(REG_SLOW_PERIOD, slow_pick);

      phase_len = $urandom_range(60, 200);
      for (int k = 0; k < phase_len && fed < RAND_ITEMS; k++) begin
        if (phase == SQUEEZE_PHASE && k == 20) squeeze_req = 1'b1;
        // occasional mid-phase pause until every action is back
        if (k == phase_len / 2 && $urandom_range(0, 2) == 0) drain_results();
        offer_price(next_price(), 2'($urandom_range(0, 3)), 1'b0, ACT_NONE);
        fed++;
      end
      drain_results();
      phase++;
    end

    // catch any stray late transfer
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/macs_pkg.sv
sv/macs_ram.sv
sv/moving_average_crossover_signal.sv
tb/tb_top.sv
